FILE: rtl/hvr_pkg.sv
// Shared types, constants and helper functions for the hue/value to RGB pipeline.
package hvr_pkg;

   localparam logic [16:0] ONE_Q16       = 17'd65536;
   localparam int          SECTOR_COUNT  = 6;

   localparam logic [2:0] SECTOR_0    = 3'd0;
   localparam logic [2:0] SECTOR_1    = 3'd1;
   localparam logic [2:0] SECTOR_2    = 3'd2;
   localparam logic [2:0] SECTOR_3    = 3'd3;
   localparam logic [2:0] SECTOR_4    = 3'd4;
   localparam logic [2:0] SECTOR_5    = 3'd5;
   localparam logic [2:0] SECTOR_WRAP = 3'd6;

   localparam logic [2:0] CSR_HUE_SAMPLE_LOW    = 3'd0;
   localparam logic [2:0] CSR_HUE_SAMPLE_HIGH   = 3'd1;
   localparam logic [2:0] CSR_VALUE_SAMPLE_LOW  = 3'd2;
   localparam logic [2:0] CSR_VALUE_SAMPLE_HIGH = 3'd3;
   localparam logic [2:0] CSR_HUE_OFFSET        = 3'd4;
   localparam logic [2:0] CSR_HUE_GAIN          = 3'd5;
   localparam logic [2:0] CSR_VALUE_GAIN        = 3'd6;

   typedef struct packed {
      logic signed [31:0] hue_sample_low;
      logic signed [31:0] hue_sample_high;
      logic signed [31:0] value_sample_low;
      logic signed [31:0] value_sample_high;
      logic        [16:0] hue_offset;
      logic signed [31:0] hue_gain;
      logic        [31:0] value_gain;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] hue_sample;
      logic signed [31:0] value_sample;
      logic               last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [31:0] dh;
      logic [31:0] dv;
      logic        last_pixel;
   } dist_type;

   typedef struct packed {
      logic signed [64:0] hprod;
      logic        [63:0] vprod;
      logic               last_pixel;
   } prod_type;

   typedef struct packed {
      logic [16:0] hue;
      logic [16:0] v;
      logic        last_pixel;
   } hv_type;

   typedef struct packed {
      logic [2:0]  sector;
      logic [16:0] v;
      logic        zero_sat;
      logic [15:0] sf;
      logic [16:0] sf1;
      logic [16:0] p;
      logic        last_pixel;
   } sect_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        end_of_image;
   } rgb_type;

   function automatic logic [31:0] clip_dist(input logic signed [31:0] x,
                                             input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
      logic signed [31:0] c;
      logic        [32:0] d;
      c = x;
      if (c >= hi) c = hi;
      if (c <= lo) c = lo;
      d = {c[31], c} - {lo[31], lo};
      return d[31:0];
   endfunction

   function automatic logic [15:0] sat16(input logic [16:0] x);
      return x[16] ? 16'hFFFF : x[15:0];
   endfunction

endpackage

FILE: rtl/hue_value_to_rgb_pixel.sv
// Throughput: one item per cycle while rsp_tready is high; five registered stages
// (clip, gain multiply, scale and saturate, sector and s-products, component mix)
// each with a valid bit.
// Each stage is ready when empty or when the stage after it advances.
// Reset (synchronous) empties all stages and loads the csr registers with defaults.
module hue_value_to_rgb_pixel
   import hvr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // hue_sample[31:0], value_sample[63:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // red[15:0], green[31:16], blue[47:32]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   pixel_type req_pixel;
   logic      s1_valid, s2_valid, s3_valid, s4_valid;
   logic      s1_ready, s2_ready, s3_ready, s4_ready;
   dist_type  s1_data;
   prod_type  s2_data;
   hv_type    s3_data;
   sect_type  s4_data;
   rgb_type   rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HUE_SAMPLE_LOW:    cfg_in.hue_sample_low    = csr_wdata;
            CSR_HUE_SAMPLE_HIGH:   cfg_in.hue_sample_high   = csr_wdata;
            CSR_VALUE_SAMPLE_LOW:  cfg_in.value_sample_low  = csr_wdata;
            CSR_VALUE_SAMPLE_HIGH: cfg_in.value_sample_high = csr_wdata;
            CSR_HUE_OFFSET:        cfg_in.hue_offset        = csr_wdata[16:0];
            CSR_HUE_GAIN:          cfg_in.hue_gain          = csr_wdata;
            CSR_VALUE_GAIN:        cfg_in.value_gain        = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_sample_low    <= 32'sd0;
         cfg_ff.hue_sample_high   <= 32'sd65536;
         cfg_ff.value_sample_low  <= 32'sd0;
         cfg_ff.value_sample_high <= 32'sd65536;
         cfg_ff.hue_offset        <= 17'd0;
         cfg_ff.hue_gain          <= 32'sd16777216;
         cfg_ff.value_gain        <= 32'd16777216;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_pixel.hue_sample   = req_tdata[31:0];
   assign req_pixel.value_sample = req_tdata[63:32];
   assign req_pixel.last_pixel   = req_tlast;

   hvr_clip u_clip (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_data  (req_pixel),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_data  (s1_data)
   );

   hvr_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (s1_valid),
      .up_ready (s1_ready),
      .up_data  (s1_data),
      .dn_valid (s2_valid),
      .dn_ready (s2_ready),
      .dn_data  (s2_data)
   );

   hvr_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (s2_valid),
      .up_ready (s2_ready),
      .up_data  (s2_data),
      .dn_valid (s3_valid),
      .dn_ready (s3_ready),
      .dn_data  (s3_data)
   );

   hvr_sector u_sector (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s3_valid),
      .up_ready (s3_ready),
      .up_data  (s3_data),
      .dn_valid (s4_valid),
      .dn_ready (s4_ready),
      .dn_data  (s4_data)
   );

   hvr_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s4_valid),
      .up_ready (s4_ready),
      .up_data  (s4_data),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (rsp_data)
   );

   assign rsp_tdata = {rsp_data.blue, rsp_data.green, rsp_data.red};
   assign rsp_tlast = rsp_data.end_of_image;

`ifndef NO_ASSERTIONS
   a_empty_out_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   a_hv_range : assert property (@(posedge clock) disable iff (reset)
      s3_valid |-> (s3_data.hue <= ONE_Q16) && (s3_data.v <= ONE_Q16))
      else $error("hue or value beyond one");

   a_sector_range : assert property (@(posedge clock) disable iff (reset)
      s4_valid |-> s4_data.sector <= SECTOR_5)
      else $error("sector not wrapped");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

FILE: rtl/hvr_clip.sv
// Stage 1: clip both samples and take their distance above the lower bounds.
module hvr_clip
   import hvr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      up_valid,
   output logic      up_ready,
   input  pixel_type up_data,
   output logic      dn_valid,
   input  logic      dn_ready,
   output dist_type  dn_data
);

   logic     valid_ff, valid_in;
   dist_type data_ff, data_in;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (up_ready) begin
         valid_in           = up_valid;
         data_in.dh         = clip_dist(up_data.hue_sample, cfg.hue_sample_low,
                                        cfg.hue_sample_high);
         data_in.dv         = clip_dist(up_data.value_sample, cfg.value_sample_low,
                                        cfg.value_sample_high);
         data_in.last_pixel = up_data.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: rtl/hvr_mul.sv
// Stage 2: multiply both distances by their gains.
module hvr_mul
   import hvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     up_valid,
   output logic     up_ready,
   input  dist_type up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output prod_type dn_data
);

   logic     valid_ff, valid_in;
   prod_type data_ff, data_in;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (up_ready) begin
         valid_in           = up_valid;
         data_in.hprod      = 65'($signed({1'b0, up_data.dh})) * 65'(cfg.hue_gain);
         data_in.vprod      = 64'(up_data.dv) * 64'(cfg.value_gain);
         data_in.last_pixel = up_data.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: rtl/hvr_scale.sv
// Stage 3: scale products to Q1.16, add the hue offset and saturate hue and value.
module hvr_scale
   import hvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     up_valid,
   output logic     up_ready,
   input  prod_type up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output hv_type   dn_data
);

   logic               valid_ff, valid_in;
   hv_type             data_ff, data_in;
   logic signed [40:0] hshift;
   logic signed [41:0] hsum;
   logic        [39:0] vshift;

   assign up_ready = !valid_ff || dn_ready;
   assign hshift   = up_data.hprod[64:24];
   assign hsum     = $signed({25'd0, cfg.hue_offset}) + $signed({hshift[40], hshift});
   assign vshift   = up_data.vprod[63:24];

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (up_ready) begin
         valid_in = up_valid;
         if (hsum[41]) begin
            data_in.hue = '0;
         end else if (hsum[40:0] > {24'd0, ONE_Q16}) begin
            data_in.hue = ONE_Q16;
         end else begin
            data_in.hue = hsum[16:0];
         end
         if (vshift > {23'd0, ONE_Q16}) begin
            data_in.v = ONE_Q16;
         end else begin
            data_in.v = vshift[16:0];
         end
         data_in.last_pixel = up_data.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: rtl/hvr_sector.sv
// Stage 4: find hue sector and fraction, form s*f, s*(1-f) and p.
module hvr_sector
   import hvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  hv_type   up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output sect_type dn_data
);

   logic        valid_ff, valid_in;
   sect_type    data_ff, data_in;
   logic [18:0] h6;
   logic [15:0] f;
   logic [16:0] s;
   logic [31:0] m_sf;
   logic [32:0] m_sf1;
   logic [32:0] m_p;

   assign up_ready = !valid_ff || dn_ready;
   assign h6       = {2'b00, up_data.hue} * 19'(SECTOR_COUNT);
   assign f        = h6[15:0];
   assign s        = ONE_Q16 - up_data.v;
   assign m_sf     = 32'(s) * 32'(f);
   assign m_sf1    = 33'(s) * 33'(ONE_Q16 - {1'b0, f});
   assign m_p      = 33'(up_data.v) * 33'(up_data.v);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (up_ready) begin
         valid_in = up_valid;
         if (h6[18:16] == SECTOR_WRAP) begin
            data_in.sector = SECTOR_0;
         end else begin
            data_in.sector = h6[18:16];
         end
         data_in.v          = up_data.v;
         data_in.zero_sat   = (s == '0);
         data_in.sf         = m_sf[31:16];
         data_in.sf1        = m_sf1[32:16];
         data_in.p          = m_p[32:16];
         data_in.last_pixel = up_data.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: rtl/hvr_mix.sv
// Stage 5: form q and t, route components by sector, saturate, hold the result.
module hvr_mix
   import hvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  sect_type up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output rgb_type  dn_data
);

   logic        valid_ff, valid_in;
   rgb_type     data_ff, data_in;
   logic [32:0] m_q;
   logic [32:0] m_t;
   logic [16:0] v, p, q, t;
   logic [16:0] r, g, b;

   assign up_ready = !valid_ff || dn_ready;
   assign v        = up_data.v;
   assign p        = up_data.p;
   assign m_q      = 33'(v) * 33'(ONE_Q16 - {1'b0, up_data.sf});
   assign m_t      = 33'(v) * 33'(ONE_Q16 - up_data.sf1);
   assign q        = m_q[32:16];
   assign t        = m_t[32:16];

   always_comb begin
      if (up_data.zero_sat) begin
         r = v; g = v; b = v;
      end else begin
         case (up_data.sector)
            SECTOR_0: begin r = v; g = t; b = p; end
            SECTOR_1: begin r = q; g = v; b = p; end
            SECTOR_2: begin r = p; g = v; b = t; end
            SECTOR_3: begin r = p; g = q; b = v; end
            SECTOR_4: begin r = t; g = p; b = v; end
            default:  begin r = v; g = p; b = q; end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (up_ready) begin
         valid_in             = up_valid;
         data_in.red          = sat16(r);
         data_in.green        = sat16(g);
         data_in.blue         = sat16(b);
         data_in.end_of_image = up_data.last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

FILE: bench/hue_value_to_rgb_pixel_test.sv
// Self-checking stream testbench for the hue/value to RGB pixel pipeline.
module hue_value_to_rgb_pixel_test;
   timeunit 1ns;
   timeprecision 1ps;
   import hvr_pkg::*;

   localparam logic [2:0] CSR_SPARE     = 3'd7;
   localparam int         PHASE_COUNT   = 8;
   localparam int         PHASE_ITEMS   = 170;
   localparam int         LONG_HOLD     = 300;
   localparam int         DRAIN_CYCLES  = 8;
   localparam int         CYCLE_LIMIT   = 200000;
   localparam int         REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [31:0] hue;
      logic [31:0] value;
      logic        lastp;
      logic        literal;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } pixel_row_type;

   localparam int ROW_COUNT = 22;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [63:0] req_tdata;  // hue_sample[31:0], value_sample[63:32]
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [47:0] rsp_tdata;  // red[15:0], green[31:16], blue[47:32]
   logic rsp_tlast;
   logic csr_we;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   cfg_type model_cfg;
   rgb_type rgb_expected [$];
   int      cycle_count = 0;
   int      error_count = 0;
   int      pixels_checked = 0;
   int      eoi_seen = 0;
   int      settings_loaded = 0;
   bit      sender_idles;
   bit      receiver_idles;
   bit      long_hold_armed;

   pixel_row_type pixel_rows [ROW_COUNT] = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000},
      '{32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000},
      '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{32'd100,       32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd11023,     32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd21946,     32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd32869,     32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd43792,     32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd54715,     32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd65536,     32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd65535,     32'd40000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd10922,     32'd50000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd10923,     32'd50000,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd30000,     32'd65535,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd50000,     32'd1,         1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'hFFFF_FFFF, 32'd32768,     1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'd65537,     32'd70000,     1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000}
   };

   hue_value_to_rgb_pixel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned clipped_span(input logic signed [31:0] x, lo, hi);
      longint c;
      c = longint'(x);
      if (c >= longint'(hi)) c = longint'(hi);
      if (c <= longint'(lo)) c = longint'(lo);
      return $unsigned(c - longint'(lo));
   endfunction

   function automatic logic [15:0] clamp_unit(input longint unsigned x);
      return (x > 64'd65535) ? 16'hFFFF : 16'(x);
   endfunction

   function automatic rgb_type predict_rgb(input logic signed [31:0] hs, vs,
                                           input logic lastp);
      longint unsigned dh, dv, m, v, s, h6, sect, f, p, q, t, r, g, b;
      longint gain, hue, off;
      rgb_type px;
      dh = clipped_span(hs, model_cfg.hue_sample_low, model_cfg.hue_sample_high);
      dv = clipped_span(vs, model_cfg.value_sample_low, model_cfg.value_sample_high);
      gain = longint'($signed(model_cfg.hue_gain));
      off = longint'(model_cfg.hue_offset);
      if (gain >= 0) begin
         m = dh * $unsigned(gain);
         hue = off + longint'(m >> 24);
      end else begin
         m = dh * $unsigned(-gain);
         hue = off - longint'((m + 64'hFF_FFFF) >> 24);
      end
      if (hue < 0) hue = 0;
      if (hue > longint'(ONE_Q16)) hue = longint'(ONE_Q16);
      v = (dv * 64'(model_cfg.value_gain)) >> 24;
      if (v > 64'(ONE_Q16)) v = 64'(ONE_Q16);
      s = 64'(ONE_Q16) - v;
      if (s == 0) begin
         r = v;
         g = v;
         b = v;
      end else begin
         h6 = $unsigned(hue) * 64'd6;
         sect = h6 >> 16;
         f = h6 & 64'hFFFF;
         if (sect == 64'(SECTOR_WRAP)) sect = 64'(SECTOR_0);
         p = (v * (64'(ONE_Q16) - s)) >> 16;
         q = (v * (64'(ONE_Q16) - ((s * f) >> 16))) >> 16;
         t = (v * (64'(ONE_Q16) - ((s * (64'(ONE_Q16) - f)) >> 16))) >> 16;
         case (sect)
            64'(SECTOR_0): begin r = v; g = t; b = p; end
            64'(SECTOR_1): begin r = q; g = v; b = p; end
            64'(SECTOR_2): begin r = p; g = v; b = t; end
            64'(SECTOR_3): begin r = p; g = q; b = v; end
            64'(SECTOR_4): begin r = t; g = p; b = v; end
            default: begin r = v; g = p; b = q; end
         endcase
      end
      px.red = clamp_unit(r);
      px.green = clamp_unit(g);
      px.blue = clamp_unit(b);
      px.end_of_image = lastp;
      return px;
   endfunction

   // bias toward bounds and in-range values, with some full-range noise
   function automatic logic [31:0] pick_sample(input logic signed [31:0] lo, hi);
      logic [63:0] r;
      longint span;
      int sel;
      r = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      span = longint'(hi) - longint'(lo);
      case (sel)
         0: return $urandom;
         1: return lo;
         2: return hi;
         3: return lo - 32'sd1;
         4: return hi + 32'sd1;
         default: begin
            if (span <= 0) return $urandom;
            return lo + 32'(r % 64'(span + 1));
         end
      endcase
   endfunction

   function automatic cfg_type pick_settings(input int phase);
      cfg_type c;
      int unsigned hspan, vspan;
      int hbase, vbase;
      longint hg, vg;
      hspan = $urandom_range(1024, 1 << 20);
      vspan = $urandom_range(1024, 1 << 20);
      hbase = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      vbase = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      hg = (longint'(1) << 40) / longint'(hspan);
      vg = ((longint'(1) << 40) / longint'(vspan)) * longint'($urandom_range(1, 2));
      c.hue_sample_low = hbase;
      c.hue_sample_high = hbase + int'(hspan);
      c.value_sample_low = vbase;
      c.value_sample_high = vbase + int'(vspan);
      c.value_gain = 32'(vg);
      case ($urandom_range(0, 2))
         0: begin c.hue_offset = '0; c.hue_gain = 32'(hg); end
         1: begin c.hue_offset = ONE_Q16; c.hue_gain = 32'(-hg); end
         default: begin c.hue_offset = 17'($urandom_range(0, ONE_Q16)); c.hue_gain = 32'(hg); end
      endcase
      case (phase)
         1: begin
            c.hue_sample_low = 32'h8000_0000;
            c.hue_sample_high = 32'h7FFF_FFFF;
            c.value_sample_low = 32'h8000_0000;
            c.value_sample_high = 32'h7FFF_FFFF;
            c.hue_offset = ONE_Q16;
            c.hue_gain = 32'h8000_0000;
            c.value_gain = 32'hFFFF_FFFF;
         end
         2: begin
            c.hue_sample_low = 32'h7FFF_FFFF;
            c.hue_sample_high = 32'h8000_0000;
            c.hue_gain = 32'h7FFF_FFFF;
         end
         3: begin
            c.value_sample_low = vbase + int'(vspan);
            c.value_sample_high = vbase;
         end
         4: c.value_gain = '0;
         6: begin
            c.hue_sample_low = $urandom;
            c.hue_sample_high = $urandom;
            c.value_sample_low = $urandom;
            c.value_sample_high = $urandom;
            c.hue_offset = 17'($urandom_range(0, ONE_Q16));
            c.hue_gain = $urandom;
            c.value_gain = $urandom;
         end
         7: begin
            c.hue_offset = 17'($urandom_range(0, ONE_Q16));
            c.hue_gain = '0;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic write_register(input logic [2:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_HUE_SAMPLE_LOW:    model_cfg.hue_sample_low = data;
         CSR_HUE_SAMPLE_HIGH:   model_cfg.hue_sample_high = data;
         CSR_VALUE_SAMPLE_LOW:  model_cfg.value_sample_low = data;
         CSR_VALUE_SAMPLE_HIGH: model_cfg.value_sample_high = data;
         CSR_HUE_OFFSET:        model_cfg.hue_offset = data[16:0];
         CSR_HUE_GAIN:          model_cfg.hue_gain = data;
         CSR_VALUE_GAIN:        model_cfg.value_gain = data;
         default: ;
      endcase
   endtask

   task automatic load_settings(input cfg_type c);
      write_register(CSR_HUE_SAMPLE_LOW, c.hue_sample_low);
      write_register(CSR_HUE_SAMPLE_HIGH, c.hue_sample_high);
      write_register(CSR_VALUE_SAMPLE_LOW, c.value_sample_low);
      write_register(CSR_VALUE_SAMPLE_HIGH, c.value_sample_high);
      write_register(CSR_HUE_OFFSET, {15'd0, c.hue_offset});
      write_register(CSR_HUE_GAIN, c.hue_gain);
      write_register(CSR_VALUE_GAIN, c.value_gain);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_pixel(input logic [31:0] hs, vs, input logic lastp,
                             input logic literal, input rgb_type fixed_rgb);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vs, hs};
      req_tlast <= lastp;
      do @(posedge clock); while (!req_tready);
      rgb_expected.push_back(literal ? fixed_rgb : predict_rgb(hs, vs, lastp));
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) begin
         send_pixel(pick_sample(model_cfg.hue_sample_low, model_cfg.hue_sample_high),
                    pick_sample(model_cfg.value_sample_low, model_cfg.value_sample_high),
                    $urandom_range(0, 15) == 0, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (rgb_expected.size() != 0) @(posedge clock);
   endtask

   initial begin : receiver
      int hold_cycles;
      hold_cycles = 0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_cycles == 0 && long_hold_armed) begin
            hold_cycles = LONG_HOLD;
            long_hold_armed = 1'b0;
         end else if (hold_cycles == 0 && receiver_idles && $urandom_range(0, 3) == 0) begin
            hold_cycles = $urandom_range(1, 4);
         end
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rgb_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red = rsp_tdata[15:0];
         got.green = rsp_tdata[31:16];
         got.blue = rsp_tdata[47:32];
         got.end_of_image = rsp_tlast;
         pixels_checked++;
         if (got.end_of_image) eoi_seen++;
         if (rgb_expected.size() == 0) begin
            if (error_count < REPORT_LIMIT)
               $display("pixel %0d: result with nothing expected, got %04h %04h %04h last %b",
                        pixels_checked, got.red, got.green, got.blue, got.end_of_image);
            error_count++;
         end else begin
            want = rgb_expected.pop_front();
            if (got !== want) begin
               if (error_count < REPORT_LIMIT)
                  $display("pixel %0d: expected %04h %04h %04h last %b, got %04h %04h %04h last %b",
                           pixels_checked, want.red, want.green, want.blue, want.end_of_image,
                           got.red, got.green, got.blue, got.end_of_image);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("hue_value_to_rgb_pixel_test: done, errors");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_HUE_SAMPLE_LOW;
      csr_wdata = '0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      long_hold_armed = 1'b0;
      model_cfg = '{hue_sample_low: 32'sd0, hue_sample_high: 32'sd65536,
                    value_sample_low: 32'sd0, value_sample_high: 32'sd65536,
                    hue_offset: 17'd0, hue_gain: 32'sd16777216,
                    value_gain: 32'd16777216};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (pixel_rows[i]) begin
         send_pixel(pixel_rows[i].hue, pixel_rows[i].value, pixel_rows[i].lastp,
                    pixel_rows[i].literal,
                    rgb_type'{pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue,
                              pixel_rows[i].lastp});
      end
      req_tvalid <= 1'b0;
      wait_idle();
      // the spare index must leave every register untouched
      write_register(CSR_SPARE, $urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      send_random(PHASE_ITEMS);
      for (int phase = 1; phase <= PHASE_COUNT; phase++) begin
         wait_idle();
         sender_idles = (phase != 5 && phase != PHASE_COUNT);
         receiver_idles = (phase != 5 && phase != PHASE_COUNT);
         load_settings(pick_settings(phase));
         if (phase == 3) long_hold_armed = 1'b1;
         send_random(PHASE_ITEMS);
      end
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += rgb_expected.size();
      $display("checked %0d pixels (%0d end-of-image) under %0d register settings,",
               pixels_checked, eoi_seen, settings_loaded + 1);
      $display("with clipped, crossed and extreme bounds and gains, stalls and a long hold");
      if (error_count == 0) begin
         $display("hue_value_to_rgb_pixel_test: done, clean");
      end else begin
         $display("hue_value_to_rgb_pixel_test: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/hvr_pkg.sv
rtl/hvr_clip.sv
rtl/hvr_mul.sv
rtl/hvr_scale.sv
rtl/hvr_sector.sv
rtl/hvr_mix.sv
rtl/hue_value_to_rgb_pixel.sv
bench/hue_value_to_rgb_pixel_test.sv
